@@ rtl/mcct_pkg.sv @@
// Shared constants, command codes and types for the compare timer.
// Used by mcct_ticks, mcct_core and multi_channel_compare_timer_top.
package mcct_pkg;

  localparam int TICK_FREQ_HZ = 16384;

  localparam int CMD_W      = 3;
  localparam int MS_W       = 16;
  localparam int TICK_W     = 16;
  localparam int USERS_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MS_PER_S       = 1000;
  localparam int PERIOD_20HZ_MS = 50;

  // ms * TICK_FREQ_HZ, then an exact divide by 1000 via a reciprocal multiply
  localparam int FREQ_W = $clog2(TICK_FREQ_HZ + 1);
  localparam longint unsigned PROD_MAX =
    ((longint'(1) << MS_W) - 1) * longint'(TICK_FREQ_HZ);
  localparam int PROD_W    = $clog2(PROD_MAX + 1);
  localparam int DIV_SHIFT = PROD_W + $clog2(MS_PER_S);
  localparam longint unsigned RECIP_VAL =
    ((longint'(1) << DIV_SHIFT) + longint'(MS_PER_S) - 1) / longint'(MS_PER_S);
  localparam int RECIP_W = $clog2(RECIP_VAL + 1);

  localparam logic [FREQ_W-1:0]  TICK_FREQ = FREQ_W'(TICK_FREQ_HZ);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_VAL);

  localparam logic [TICK_W-1:0] PERIOD_20HZ_RST =
    TICK_W'((TICK_FREQ_HZ * PERIOD_20HZ_MS) / MS_PER_S);

  localparam logic [USERS_W-1:0] USERS_MAX = '1;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START_20HZ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP_20HZ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELAY       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CB_DELAY    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CB_CANCEL   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PER_CREATE  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_PER_DESTROY = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OVF_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TICK_W-1:0] ticks;
  } mcct_item_t;

  typedef struct packed {
    logic                event_20hz;
    logic                event_periodic;
    logic                event_overflow;
    logic                delay_done;
    logic                callback_fire;
    logic                wake;
    logic [TICK_W-1:0]   count_20hz;
    logic [USERS_W-1:0]  users_20hz;
  } mcct_result_t;

endpackage

@@ rtl/mcct_ticks.sv @@
// Front pipeline: registers the command and converts milliseconds to ticks.
// Three stages: input, ms * tick rate, reciprocal multiply. Uses mcct_pkg.
module mcct_ticks import mcct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [MS_W-1:0]   in_duration_ms,
  output logic              item_valid,
  input  logic              item_ready,
  output mcct_item_t        item
);

  localparam int MUL1_W = MS_W + FREQ_W;
  localparam int MUL2_W = PROD_W + RECIP_W;

  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [MS_W-1:0]   s1_ms_r;
  logic              s2_valid_r;
  logic [CMD_W-1:0]  s2_cmd_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic              s3_valid_r;
  logic [CMD_W-1:0]  s3_cmd_r;
  logic [TICK_W-1:0] s3_ticks_r;

  logic              s1_ready;
  logic              s2_ready;
  logic              s3_ready;
  logic [MUL1_W-1:0] mul1;
  logic [MUL2_W-1:0] mul2;
  logic [PROD_W-1:0] s2_prod_nxt;
  logic [TICK_W-1:0] s3_ticks_nxt;

  assign s3_ready = ~s3_valid_r | item_ready;
  assign s2_ready = ~s2_valid_r | s3_ready;
  assign s1_ready = ~s1_valid_r | s2_ready;
  assign in_stall = ~s1_ready;

  assign mul1 = {{FREQ_W{1'b0}}, s1_ms_r} * {{MS_W{1'b0}}, TICK_FREQ};
  assign s2_prod_nxt = mul1[PROD_W-1:0];

  // exact floor divide by 1000; keep the low tick bits of the quotient
  assign mul2 = {{RECIP_W{1'b0}}, s2_prod_r} * {{PROD_W{1'b0}}, RECIP};
  assign s3_ticks_nxt = mul2[DIV_SHIFT +: TICK_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cmd_r <= in_cmd;
      s1_ms_r  <= in_duration_ms;
    end
    if (s2_ready) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_prod_r <= s2_prod_nxt;
    end
    if (s3_ready) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_ticks_r <= s3_ticks_nxt;
    end
  end

  assign item_valid = s3_valid_r;
  assign item.cmd   = s3_cmd_r;
  assign item.ticks = s3_ticks_r;

endmodule

@@ rtl/mcct_core.sv @@
// Timer state, compare channels, configuration registers and result register.
// Takes converted commands from mcct_ticks. Uses mcct_pkg.
module mcct_core import mcct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  mcct_item_t            item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output mcct_result_t          res
);

  logic               ovf_en_r;
  logic [TICK_W-1:0]  period_20hz_r;

  logic [TICK_W-1:0]  tick_r,       tick_nxt;
  logic [TICK_W-1:0]  cmp_20hz_r,   cmp_20hz_nxt;
  logic [USERS_W-1:0] users_r,      users_nxt;
  logic [TICK_W-1:0]  count_20hz_r, count_20hz_nxt;
  logic [TICK_W-1:0]  cmp_cb_r,     cmp_cb_nxt;
  logic               cb_armed_r,   cb_armed_nxt;
  logic [TICK_W-1:0]  cmp_per_r,    cmp_per_nxt;
  logic [TICK_W-1:0]  per_ticks_r,  per_ticks_nxt;
  logic               per_en_r,     per_en_nxt;
  logic [TICK_W-1:0]  cmp_dly_r,    cmp_dly_nxt;
  logic               dly_en_r,     dly_en_nxt;

  logic               res_valid_r;
  mcct_result_t       res_r, res_nxt;

  logic               take;
  logic [TICK_W-1:0]  tick_inc;
  logic [TICK_W-1:0]  armed_cmp;

  assign cfg_ready  = 1'b1;
  assign item_ready = ~res_valid_r | ~res_stall;
  assign take       = item_valid & item_ready;
  assign tick_inc   = tick_r + 1'b1;
  assign armed_cmp  = tick_r + item.ticks;

  always_comb begin
    tick_nxt       = tick_r;
    cmp_20hz_nxt   = cmp_20hz_r;
    users_nxt      = users_r;
    count_20hz_nxt = count_20hz_r;
    cmp_cb_nxt     = cmp_cb_r;
    cb_armed_nxt   = cb_armed_r;
    cmp_per_nxt    = cmp_per_r;
    per_ticks_nxt  = per_ticks_r;
    per_en_nxt     = per_en_r;
    cmp_dly_nxt    = cmp_dly_r;
    dly_en_nxt     = dly_en_r;
    res_nxt        = '0;

    unique case (item.cmd)
      CMD_TICK: begin
        tick_nxt = tick_inc;
        res_nxt.event_overflow = ovf_en_r & (tick_inc == '0);
        if ((users_r != '0) && (cmp_20hz_r == tick_inc)) begin
          res_nxt.event_20hz = 1'b1;
          cmp_20hz_nxt       = cmp_20hz_r + period_20hz_r;
          count_20hz_nxt     = count_20hz_r + 1'b1;
        end
        if (per_en_r && (cmp_per_r == tick_inc)) begin
          res_nxt.event_periodic = 1'b1;
          cmp_per_nxt            = cmp_per_r + per_ticks_r;
        end
        if (dly_en_r && (cmp_dly_r == tick_inc)) begin
          res_nxt.delay_done = 1'b1;
          dly_en_nxt         = 1'b0;
        end
        if (cb_armed_r && (cmp_cb_r == tick_inc)) begin
          res_nxt.callback_fire = 1'b1;
          cb_armed_nxt          = 1'b0;
        end
      end
      CMD_START_20HZ: begin
        // first user sets the phase; later users only add to the count
        if (users_r == '0) cmp_20hz_nxt = tick_r + period_20hz_r;
        if (users_r != USERS_MAX) users_nxt = users_r + 1'b1;
      end
      CMD_STOP_20HZ: begin
        if (users_r != '0) users_nxt = users_r - 1'b1;
      end
      CMD_DELAY: begin
        cmp_dly_nxt = armed_cmp;
        dly_en_nxt  = 1'b1;
      end
      CMD_CB_DELAY: begin
        cmp_cb_nxt   = armed_cmp;
        cb_armed_nxt = 1'b1;
      end
      CMD_CB_CANCEL: begin
        cb_armed_nxt = 1'b0;
      end
      CMD_PER_CREATE: begin
        per_ticks_nxt = item.ticks;
        cmp_per_nxt   = armed_cmp;
        per_en_nxt    = 1'b1;
      end
      CMD_PER_DESTROY: begin
        per_en_nxt = 1'b0;
      end
      default: begin
        per_en_nxt = per_en_r;
      end
    endcase

    res_nxt.wake = res_nxt.event_20hz | res_nxt.event_periodic |
                   res_nxt.event_overflow | res_nxt.delay_done;
    res_nxt.count_20hz = count_20hz_nxt;
    res_nxt.users_20hz = users_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_en_r      <= 1'b0;
      period_20hz_r <= PERIOD_20HZ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_OVF_EN: ovf_en_r      <= cfg_data[0];
        CFG_IDX_PERIOD: period_20hz_r <= cfg_data;
        default:        ovf_en_r      <= ovf_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      cmp_20hz_r   <= '0;
      users_r      <= '0;
      count_20hz_r <= '0;
      cmp_cb_r     <= '0;
      cb_armed_r   <= 1'b0;
      cmp_per_r    <= '0;
      per_ticks_r  <= '0;
      per_en_r     <= 1'b0;
      cmp_dly_r    <= '0;
      dly_en_r     <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        tick_r       <= tick_nxt;
        cmp_20hz_r   <= cmp_20hz_nxt;
        users_r      <= users_nxt;
        count_20hz_r <= count_20hz_nxt;
        cmp_cb_r     <= cmp_cb_nxt;
        cb_armed_r   <= cb_armed_nxt;
        cmp_per_r    <= cmp_per_nxt;
        per_ticks_r  <= per_ticks_nxt;
        per_en_r     <= per_en_nxt;
        cmp_dly_r    <= cmp_dly_nxt;
        dly_en_r     <= dly_en_nxt;
        res_valid_r  <= 1'b1;
      end else if (!res_stall) begin
        res_valid_r  <= 1'b0;
      end
    end
  end

  // result payload, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ rtl/multi_channel_compare_timer_top.sv @@
// Top level of the multi-channel compare timer.
// Instantiates mcct_ticks and mcct_core; uses mcct_pkg.
//
// Each input transfer is one command: cmd 0 is a timer tick, the others arm,
// cancel or reference-count the compare channels, with in_duration_ms in
// milliseconds where the command needs a delay or period. Every input
// transfer yields exactly one result transfer, in order, carrying the event
// flags for that step plus the 20 Hz event count and user count.
// From input transfer to out_valid a command passes the input register, then
// the ms times tick rate stage, the reciprocal multiply for the divide by 1000
// and the channel update into the result register.
// Throughput is one item per cycle while out_stall is low; the two multiplier stages set the depth.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is the overflow event enable, index 1 the 20 Hz period in
// ticks, other indexes are ignored. Write it only while the block is idle.
// Synchronous reset (rst_n low) clears the counter and all channels, empties
// the pipeline and loads the 20 Hz period with 819 ticks.
// When out_stall is high the result holds; bubbles in the pipeline still
// fill, and in_stall rises once every stage holds an item.
module multi_channel_compare_timer_top import mcct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [MS_W-1:0]       in_duration_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_event_20hz,
  output logic                  out_event_periodic,
  output logic                  out_event_overflow,
  output logic                  out_delay_done,
  output logic                  out_callback_fire,
  output logic                  out_wake,
  output logic [TICK_W-1:0]     out_count_20hz_out,
  output logic [USERS_W-1:0]    out_users_20hz,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic         item_valid;
  logic         item_ready;
  mcct_item_t   item;
  mcct_result_t res;

  mcct_ticks u_ticks (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_duration_ms (in_duration_ms),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  mcct_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign out_event_20hz     = res.event_20hz;
  assign out_event_periodic = res.event_periodic;
  assign out_event_overflow = res.event_overflow;
  assign out_delay_done     = res.delay_done;
  assign out_callback_fire  = res.callback_fire;
  assign out_wake           = res.wake;
  assign out_count_20hz_out = res.count_20hz;
  assign out_users_20hz     = res.users_20hz;

endmodule

@@ tb/multi_channel_compare_timer_top_tb.sv @@
// Self-checking testbench for multi_channel_compare_timer_top: drives timer commands,
// predicts every result in lockstep and compares field by field.
// Depends on mcct_pkg and the timer RTL under rtl/.
module multi_channel_compare_timer_top_tb import mcct_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [MS_W-1:0]  ms;
  } timer_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [MS_W-1:0]       in_duration_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_event_20hz;
  logic                  out_event_periodic;
  logic                  out_event_overflow;
  logic                  out_delay_done;
  logic                  out_callback_fire;
  logic                  out_wake;
  logic [TICK_W-1:0]     out_count_20hz_out;
  logic [USERS_W-1:0]    out_users_20hz;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multi_channel_compare_timer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_duration_ms     (in_duration_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_20hz     (out_event_20hz),
    .out_event_periodic (out_event_periodic),
    .out_event_overflow (out_event_overflow),
    .out_delay_done     (out_delay_done),
    .out_callback_fire  (out_callback_fire),
    .out_wake           (out_wake),
    .out_count_20hz_out (out_count_20hz_out),
    .out_users_20hz     (out_users_20hz),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Timer model state and register copies
  logic [TICK_W-1:0]  tm_count     = '0;
  logic [TICK_W-1:0]  tm_cmp_20hz  = '0;
  logic [USERS_W-1:0] tm_users     = '0;
  logic [TICK_W-1:0]  tm_n20hz     = '0;
  logic [TICK_W-1:0]  tm_cmp_cb    = '0;
  logic               tm_cb_armed  = 1'b0;
  logic [TICK_W-1:0]  tm_cmp_per   = '0;
  logic [TICK_W-1:0]  tm_per_ticks = '0;
  logic               tm_per_en    = 1'b0;
  logic [TICK_W-1:0]  tm_cmp_dly   = '0;
  logic               tm_dly_en    = 1'b0;
  logic               reg_ovf_en   = 1'b0;
  logic [TICK_W-1:0]  reg_period   = PERIOD_20HZ_RST;

  timer_cmd_t   cmd_q[$];
  mcct_result_t expected_results[$];

  bit          in_took;
  bit          out_took;
  bit          hold_out = 1'b0;
  int unsigned in_idle_max = 0;
  int unsigned out_idle_max = 0;
  int          n_items, n_ticks, n_results, n_errors;
  int          seen_20hz, seen_per, seen_ovf, seen_dly, seen_cb, peak_users;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [TICK_W-1:0] ms_in_ticks(logic [MS_W-1:0] ms);
    logic [63:0] prod;
    prod = 64'(ms) * 64'(TICK_FREQ_HZ);
    return TICK_W'(prod / 64'(MS_PER_S));
  endfunction

  task automatic apply_command(input timer_cmd_t c, output mcct_result_t r);
    logic [TICK_W-1:0] dt;
    dt = ms_in_ticks(c.ms);
    r = '0;
    case (c.cmd)
      CMD_TICK: begin
        tm_count = tm_count + 1'b1;
        if (tm_count == '0 && reg_ovf_en) r.event_overflow = 1'b1;
        if (tm_users != '0 && tm_cmp_20hz == tm_count) begin
          r.event_20hz = 1'b1;
          tm_cmp_20hz = tm_cmp_20hz + reg_period;
          tm_n20hz = tm_n20hz + 1'b1;
        end
        if (tm_per_en && tm_cmp_per == tm_count) begin
          r.event_periodic = 1'b1;
          tm_cmp_per = tm_cmp_per + tm_per_ticks;
        end
        if (tm_dly_en && tm_cmp_dly == tm_count) begin
          r.delay_done = 1'b1;
          tm_dly_en = 1'b0;
        end
        if (tm_cb_armed && tm_cmp_cb == tm_count) begin
          r.callback_fire = 1'b1;
          tm_cb_armed = 1'b0;
        end
      end
      CMD_START_20HZ: begin
        // first user sets the compare; later users only count
        if (tm_users == '0) tm_cmp_20hz = tm_count + reg_period;
        if (tm_users != USERS_MAX) tm_users = tm_users + 1'b1;
      end
      CMD_STOP_20HZ: begin
        if (tm_users != '0) tm_users = tm_users - 1'b1;
      end
      CMD_DELAY: begin
        tm_cmp_dly = tm_count + dt;
        tm_dly_en = 1'b1;
      end
      CMD_CB_DELAY: begin
        tm_cmp_cb = tm_count + dt;
        tm_cb_armed = 1'b1;
      end
      CMD_CB_CANCEL: begin
        tm_cb_armed = 1'b0;
      end
      CMD_PER_CREATE: begin
        tm_per_ticks = dt;
        tm_cmp_per = tm_count + dt;
        tm_per_en = 1'b1;
      end
      CMD_PER_DESTROY: begin
        tm_per_en = 1'b0;
      end
      default: ;
    endcase
    r.wake = r.event_20hz | r.event_periodic | r.event_overflow | r.delay_done;
    r.count_20hz = tm_n20hz;
    r.users_20hz = tm_users;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
               n_results, field, got, want);
  endtask

  // Transfer bookkeeping, prediction and checking on the rising edge
  always @(posedge clk) begin : track
    timer_cmd_t   got_cmd;
    mcct_result_t want;
    in_took = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (in_took) begin
      got_cmd.cmd = in_cmd;
      got_cmd.ms = in_duration_ms;
      apply_command(got_cmd, want);
      expected_results.push_back(want);
      n_items++;
      if (in_cmd == CMD_TICK) n_ticks++;
    end
    if (out_took) begin
      n_results++;
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'(out_valid), 32'd0);
      end else begin
        want = expected_results.pop_front();
        seen_20hz += want.event_20hz;
        seen_per += want.event_periodic;
        seen_ovf += want.event_overflow;
        seen_dly += want.delay_done;
        seen_cb += want.callback_fire;
        if (want.users_20hz > peak_users) peak_users = want.users_20hz;
        if (out_event_20hz !== want.event_20hz)
          flag_mismatch("event_20hz", 32'(out_event_20hz), 32'(want.event_20hz));
        if (out_event_periodic !== want.event_periodic)
          flag_mismatch("event_periodic", 32'(out_event_periodic), 32'(want.event_periodic));
        if (out_event_overflow !== want.event_overflow)
          flag_mismatch("event_overflow", 32'(out_event_overflow), 32'(want.event_overflow));
        if (out_delay_done !== want.delay_done)
          flag_mismatch("delay_done", 32'(out_delay_done), 32'(want.delay_done));
        if (out_callback_fire !== want.callback_fire)
          flag_mismatch("callback_fire", 32'(out_callback_fire), 32'(want.callback_fire));
        if (out_wake !== want.wake)
          flag_mismatch("wake", 32'(out_wake), 32'(want.wake));
        if (out_count_20hz_out !== want.count_20hz)
          flag_mismatch("count_20hz_out", 32'(out_count_20hz_out), 32'(want.count_20hz));
        if (out_users_20hz !== want.users_20hz)
          flag_mismatch("users_20hz", 32'(out_users_20hz), 32'(want.users_20hz));
      end
    end
  end

  // Command driver: hold while stalled, otherwise wait out the gap and advance
  always @(negedge clk) begin : drive_cmds
    timer_cmd_t  nxt;
    int unsigned gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        nxt = cmd_q.pop_front();
        in_cmd <= nxt.cmd;
        in_duration_ms <= nxt.ms;
        in_valid <= 1'b1;
        gap_left = $urandom_range(0, in_idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each transfer, plus the long hold-off
  always @(negedge clk) begin : drive_stall
    int unsigned stall_left;
    if (out_took) stall_left = $urandom_range(0, out_idle_max);
    if (hold_out) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long receiver hold-off while commands keep coming, to back up the pipeline
  initial begin
    wait (n_items >= 400);
    @(negedge clk);
    hold_out <= 1'b1;
    repeat (100) @(negedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending", expected_results.size());
    $display("multi_channel_compare_timer_top verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_OVF_EN: reg_ovf_en = val[0];
      CFG_IDX_PERIOD: reg_period = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [MS_W-1:0] ms);
    timer_cmd_t c;
    c.cmd = cmd;
    c.ms = ms;
    cmd_q.push_back(c);
  endtask

  task automatic settle_pipeline();
    do @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  // Mostly ticks with short arming durations so events fire often;
  // a few zero and full-range durations mixed in
  task automatic push_random_cmds(input int n);
    int          left;
    int unsigned r;
    logic [MS_W-1:0] ms;
    left = n;
    while (left > 0) begin
      in_idle_max = pick_idle();
      out_idle_max = pick_idle();
      for (int i = 0; i < 50 && left > 0; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) ms = '0;
        else if (r <= 2) ms = MS_W'($urandom);
        else ms = MS_W'($urandom_range(1, 30));
        if ($urandom_range(0, 99) < 55) push_cmd(CMD_TICK, ms);
        else push_cmd(CMD_W'($urandom_range(1, 7)), ms);
        left--;
      end
      while (cmd_q.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every command, reference-count edges, zero and max durations
    write_reg(CFG_IDX_OVF_EN, 16'h0001);
    write_reg(CFG_IDX_PERIOD, 16'd1);
    in_idle_max = 3;
    out_idle_max = 3;
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_START_20HZ, '1);
    push_cmd(CMD_START_20HZ, '0);
    push_cmd(CMD_TICK, '1);
    push_cmd(CMD_TICK, '0);
    push_cmd(CMD_STOP_20HZ, '0);
    push_cmd(CMD_STOP_20HZ, '1);
    push_cmd(CMD_STOP_20HZ, '0);
    push_cmd(CMD_DELAY, '0);
    push_cmd(CMD_CB_DELAY, '1);
    push_cmd(CMD_CB_CANCEL, '1);
    push_cmd(CMD_PER_CREATE, '0);
    push_cmd(CMD_PER_DESTROY, '1);
    push_cmd(CMD_PER_CREATE, 16'd1);
    push_cmd(CMD_DELAY, 16'd1);
    push_cmd(CMD_CB_DELAY, 16'd1);
    for (int i = 0; i < 8; i++) push_cmd(CMD_TICK, MS_W'($urandom));
    settle_pipeline();

    // Short 20 Hz period, overflow off, unused index write dropped
    write_reg(CFG_IDX_OVF_EN, 16'hFFFE);
    write_reg(CFG_IDX_PERIOD, 16'd23);
    write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
    push_random_cmds(600);
    settle_pipeline();

    // Saturate the user count at both ends
    write_reg(CFG_IDX_OVF_EN, 16'h0001);
    write_reg(CFG_IDX_PERIOD, 16'hFFFF);
    in_idle_max = 2;
    out_idle_max = 2;
    for (int i = 0; i < 258; i++) push_cmd(CMD_START_20HZ, MS_W'($urandom));
    for (int i = 0; i < 4; i++) push_cmd(CMD_TICK, MS_W'($urandom));
    for (int i = 0; i < 259; i++) push_cmd(CMD_STOP_20HZ, MS_W'($urandom));
    settle_pipeline();

    // Zero period and zero durations: channels arm at the current count
    // and stay quiet over the following ticks
    write_reg(CFG_IDX_PERIOD, 16'd0);
    in_idle_max = 0;
    out_idle_max = 0;
    push_cmd(CMD_START_20HZ, '0);
    push_cmd(CMD_DELAY, '0);
    push_cmd(CMD_CB_DELAY, '0);
    push_cmd(CMD_PER_CREATE, 16'd0);
    for (int i = 0; i < 5; i++) push_cmd(CMD_TICK, '0);
    push_cmd(CMD_STOP_20HZ, '0);
    settle_pipeline();

    // Back to the reset period
    write_reg(CFG_IDX_OVF_EN, 16'h0000);
    write_reg(CFG_IDX_PERIOD, PERIOD_20HZ_RST);
    push_random_cmds(600);
    settle_pipeline();

    $display("Drove %0d commands (%0d ticks), checked %0d results, peak users %0d",
             n_items, n_ticks, n_results, peak_users);
    $display("Events: 20 Hz %0d, periodic %0d, overflow %0d, delay %0d, callback %0d",
             seen_20hz, seen_per, seen_ovf, seen_dly, seen_cb);
    if (n_errors == 0) begin
      $display("multi_channel_compare_timer_top verification clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("multi_channel_compare_timer_top verification failed");
    end
    $finish;
  end

endmodule
